/* hdl/chct_pkg.sv */
package chct_pkg;

	// field widths
	localparam int CODE_W      = 16;
	localparam int LEN_W       = 5;
	localparam int COUNT_W     = 8;
	localparam int SYM_W       = 8;
	localparam int LIDX_W      = 4;
	localparam int STORE_DEPTH = 2 ** SYM_W;

	// stream widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;

	// default sizes
	localparam int DEF_MAX_CODE_LENGTH = 16;
	localparam int DEF_MAX_SYMBOLS     = 256;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_APPEND = 2'd2,
		OP_ENCODE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BEYOND    = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic scan_start;
		logic scan_step;
		logic mem_read;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic scan_hit;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

/* hdl/chct_ctrl.sv */
module chct_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [chct_pkg::OP_W-1:0]     op,
	input  chct_pkg::sts_t                sts,
	output chct_pkg::cmd_t                cmd
);
	import chct_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					unique case (op_t'(op))
						OP_CLEAR, OP_LOAD: begin
							state_d = S_FINISH;
						end
						OP_APPEND: begin
							if (sts.full) begin
								state_d = S_FINISH;
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end
						end
						OP_ENCODE: begin
							state_d = S_READ;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit || sts.scan_last) begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
		endcase
	end

endmodule

/* hdl/chct_dp.sv */
module chct_dp #(
	parameter int MAX_CODE_LENGTH = chct_pkg::DEF_MAX_CODE_LENGTH,
	parameter int MAX_SYMBOLS     = chct_pkg::DEF_MAX_SYMBOLS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [chct_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [chct_pkg::OP_W-1:0]          s_tuser,
	input  chct_pkg::cmd_t                     cmd,
	output chct_pkg::sts_t                     sts,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [chct_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic [chct_pkg::STATUS_W-1:0]      m_tuser
);
	import chct_pkg::*;

	localparam int LIW   = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
	localparam int SUM_W = COUNT_W + $clog2(MAX_CODE_LENGTH + 1);
	localparam int TOT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int ENT_W = LEN_W + CODE_W;

	// latched item
	op_t                op_q;
	logic [LIDX_W-1:0]  lidx_q;
	logic [COUNT_W-1:0] count_q;
	logic [SYM_W-1:0]   sym_q;

	// table build state
	logic [COUNT_W-1:0] counts_q [MAX_CODE_LENGTH];
	logic [TOT_W-1:0]   total_q;
	logic [CODE_W-1:0]  prev_code_q;
	logic [LEN_W-1:0]   prev_len_q;
	logic               valid_q [STORE_DEPTH];

	// length scan
	logic [LIW-1:0]     scan_l_q;
	logic [SUM_W-1:0]   scan_sum_q;
	logic               found_q;
	logic [LEN_W-1:0]   len_q;
	logic [SUM_W-1:0]   sum_next;

	// code store, length in the upper bits
	logic [ENT_W-1:0]   mem [STORE_DEPTH];
	logic [ENT_W-1:0]   rd_q;

	// output register
	logic               m_tvalid_q;
	logic [CODE_W-1:0]  m_code_q;
	logic [LEN_W-1:0]   m_len_q;
	status_t            m_status_q;

	// result of the current item
	logic [CODE_W:0]    next_code;
	logic [LEN_W-1:0]   up_amt;
	logic [LEN_W-1:0]   dn_amt;
	logic [31:0]        up_code;
	logic [CODE_W:0]    dn_code;
	logic [CODE_W-1:0]  code_new;
	logic               append_ok;
	logic               full;
	logic [CODE_W-1:0]  res_code;
	logic [LEN_W-1:0]   res_len;
	status_t            res_status;

	// prefix sum step over the counts
	assign sum_next = scan_sum_q + SUM_W'(counts_q[scan_l_q]);
	assign full     = total_q >= TOT_W'(MAX_SYMBOLS);

	assign sts.full      = full;
	assign sts.scan_hit  = SUM_W'(total_q) < sum_next;
	assign sts.scan_last = scan_l_q == LIW'(MAX_CODE_LENGTH - 1);
	assign sts.out_free  = !m_tvalid_q || m_tready;

	// canonical next code, shifted by the length step
	assign next_code = {1'b0, prev_code_q} + (CODE_W + 1)'(1);
	assign up_amt    = len_q - prev_len_q;
	assign dn_amt    = prev_len_q - len_q;
	assign up_code   = 32'(next_code) << up_amt;
	assign dn_code   = next_code >> dn_amt;

	always_comb begin
		if (total_q == '0) begin
			code_new = '0;
		end else if (len_q >= prev_len_q) begin
			code_new = up_code[CODE_W-1:0];
		end else begin
			code_new = dn_code[CODE_W-1:0];
		end
	end

	assign append_ok = (op_q == OP_APPEND) && !full && found_q;

	// result selection
	always_comb begin
		res_code   = '0;
		res_len    = '0;
		res_status = ST_OK;
		unique case (op_q)
			OP_CLEAR, OP_LOAD: begin
				res_status = ST_OK;
			end
			OP_APPEND: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (!found_q) begin
					res_status = ST_BEYOND;
				end else begin
					res_code = code_new;
					res_len  = len_q;
				end
			end
			OP_ENCODE: begin
				if (valid_q[sym_q]) begin
					res_code = rd_q[CODE_W-1:0];
					res_len  = rd_q[ENT_W-1:CODE_W];
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
		endcase
	end

	// item latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_CLEAR;
			lidx_q  <= '0;
			count_q <= '0;
			sym_q   <= '0;
		end else if (cmd.latch) begin
			op_q    <= op_t'(s_tuser);
			lidx_q  <= s_tdata[LIDX_W-1:0];
			count_q <= s_tdata[LIDX_W+COUNT_W-1:LIDX_W];
			sym_q   <= s_tdata[LIDX_W+COUNT_W+SYM_W-1:LIDX_W+COUNT_W];
		end
	end

	// length scan, one count per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_l_q   <= '0;
			scan_sum_q <= '0;
			found_q    <= 1'b0;
			len_q      <= '0;
		end else if (cmd.scan_start) begin
			scan_l_q   <= '0;
			scan_sum_q <= '0;
			found_q    <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_sum_q <= sum_next;
			if (sts.scan_hit) begin
				found_q <= 1'b1;
				len_q   <= LEN_W'(scan_l_q) + LEN_W'(1);
			end else if (!sts.scan_last) begin
				scan_l_q <= scan_l_q + LIW'(1);
			end
		end
	end

	// table state updates on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
				counts_q[i] <= '0;
			end
			for (int i = 0; i < STORE_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
			total_q     <= '0;
			prev_code_q <= '0;
			prev_len_q  <= '0;
		end else if (cmd.commit) begin
			unique case (op_q)
				OP_CLEAR: begin
					for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
						counts_q[i] <= '0;
					end
					for (int i = 0; i < STORE_DEPTH; i++) begin
						valid_q[i] <= 1'b0;
					end
					total_q     <= '0;
					prev_code_q <= '0;
					prev_len_q  <= '0;
				end
				OP_LOAD: begin
					if ({1'b0, lidx_q} < (LIDX_W + 1)'(MAX_CODE_LENGTH)) begin
						counts_q[lidx_q[LIW-1:0]] <= count_q;
					end
				end
				OP_APPEND: begin
					if (append_ok) begin
						prev_code_q    <= code_new;
						prev_len_q     <= len_q;
						total_q        <= total_q + TOT_W'(1);
						valid_q[sym_q] <= 1'b1;
					end
				end
				OP_ENCODE: begin
				end
			endcase
		end
	end

	// code store, first copy of a symbol wins
	always_ff @(posedge clk) begin
		if (cmd.commit && append_ok && !valid_q[sym_q]) begin
			mem[sym_q] <= {len_q, code_new};
		end
		if (cmd.mem_read) begin
			rd_q <= mem[sym_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_code_q   <= res_code;
			m_len_q    <= res_len;
			m_status_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({m_len_q, m_code_q});
	assign m_tuser  = m_status_q;

	// a result is only loaded into a free output slot
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a pending word");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid_q)
		else $error("committed result not presented");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(MAX_SYMBOLS))
		else $error("append total beyond symbol limit");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_CLEAR) |=> (total_q == '0 && prev_len_q == '0))
		else $error("clear left build state behind");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (len_q != '0 && len_q <= LEN_W'(MAX_CODE_LENGTH)))
		else $error("scanned code length out of range");

endmodule

/* hdl/canonical_huffman_code_table.sv */
// Canonical Huffman code table: clear, load per-length symbol counts, append
// symbols in table order to assign canonical codes, and encode symbols by lookup.
// One item is worked at a time. Encode does one registered read of the
// 256-entry code store. Append scans the running total of the length counts
// one count per cycle until it finds the code length L (1 to MAX_CODE_LENGTH);
// an append to a full table skips the scan, and one past the counted total
// scans every length. A result waits in the output register while the next
// word is accepted, and the item after that finishes once it is taken.
module canonical_huffman_code_table #(
	parameter int MAX_CODE_LENGTH = chct_pkg::DEF_MAX_CODE_LENGTH,
	parameter int MAX_SYMBOLS     = chct_pkg::DEF_MAX_SYMBOLS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [chct_pkg::IN_TDATA_W-1:0]   s_tdata,  // length_index, count, symbol, zero pad
	input  logic [chct_pkg::OP_W-1:0]         s_tuser,  // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [chct_pkg::OUT_TDATA_W-1:0]  m_tdata,  // code, code_length, zero pad
	output logic [chct_pkg::STATUS_W-1:0]     m_tuser   // status
);
	import chct_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	chct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table state, code store and result register
	chct_dp #(
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH),
		.MAX_SYMBOLS     (MAX_SYMBOLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
